// File: hdl/cpvd_pkg.sv
// cpvd_pkg: codes, field layout, table entry types and payload decode helpers
// for the can pdo value decoder
// no dependencies; used by can_pdo_value_decoder_unit
package cpvd_pkg;

    // item operation codes (s_axis_tuser[1:0])
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // result status codes (m_axis_tuser[2:0])
    localparam logic [2:0] STAT_IGNORED  = 3'd0;
    localparam logic [2:0] STAT_UNKNOWN  = 3'd1;
    localparam logic [2:0] STAT_SHORT    = 3'd2;
    localparam logic [2:0] STAT_ACCEPTED = 3'd3;
    localparam logic [2:0] STAT_LOADED   = 3'd4;
    localparam logic [2:0] STAT_TICKED   = 3'd5;
    localparam logic [2:0] STAT_READ     = 3'd6;

    // data type codes of a definition entry
    localparam logic [2:0] TYPE_BOOL   = 3'd0;
    localparam logic [2:0] TYPE_U8     = 3'd1;
    localparam logic [2:0] TYPE_U16    = 3'd2;
    localparam logic [2:0] TYPE_U32    = 3'd3;
    localparam logic [2:0] TYPE_I8     = 3'd4;
    localparam logic [2:0] TYPE_I16    = 3'd5;
    localparam logic [2:0] TYPE_I64    = 3'd6;
    localparam logic [2:0] TYPE_UNUSED = 3'd7;

    // identifier layout and limits
    localparam int         ID_SHIFT      = 14;
    localparam logic [3:0] MAX_BYTES     = 4'd8;
    localparam logic [19:0] TIMEOUT_RESET = 20'd15000;

    // input tdata layout, lowest field first
    localparam int IN_TDATA_W = 144;
    localparam int IDX_LSB    = 0;
    localparam int OBJ_LSB    = 7;
    localparam int TYPE_LSB   = 22;
    localparam int CANID_LSB  = 25;
    localparam int LEN_LSB    = 54;
    localparam int DATA_LSB   = 58;
    localparam int TICK_LSB   = 122;

    // output tdata width (fields packed from hit_index up)
    localparam int OUT_TDATA_W = 176;

    // definition table entry
    typedef struct packed {
        logic [14:0] object_id;
        logic [2:0]  dtype;
    } def_entry_t;

    // value table entry
    typedef struct packed {
        logic        valid;
        logic [5:0]  node;
        logic [31:0] receptions;
        logic [63:0] raw;
    } value_entry_t;

    // payload bytes needed by a type, zero for the unused marker
    function automatic logic [3:0] type_bytes(input logic [2:0] t);
        logic [3:0] n;
        unique case (t)
            TYPE_BOOL, TYPE_U8, TYPE_I8: n = 4'd1;
            TYPE_U16, TYPE_I16:          n = 4'd2;
            TYPE_U32:                    n = 4'd4;
            TYPE_I64:                    n = 4'd8;
            default:                     n = 4'd0;
        endcase
        return n;
    endfunction

    // little-endian payload decode with sign extension for the signed types
    function automatic logic [63:0] decode_value(input logic [2:0] t, input logic [63:0] d);
        logic [63:0] v;
        unique case (t)
            TYPE_BOOL, TYPE_U8: v = {56'd0, d[7:0]};
            TYPE_I8:            v = {{56{d[7]}}, d[7:0]};
            TYPE_U16:           v = {48'd0, d[15:0]};
            TYPE_I16:           v = {{48{d[15]}}, d[15:0]};
            TYPE_U32:           v = {32'd0, d[31:0]};
            TYPE_I64:           v = d;
            default:            v = 64'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hdl/cpvd_ram.sv
// cpvd_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the definition and value tables
module cpvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: hdl/can_pdo_value_decoder_unit.sv
// can_pdo_value_decoder_unit: decodes can frames into a table of sensor values
// depends on cpvd_pkg and cpvd_ram
//
// states: load and tick go idle to done, read via rdata, frame via scan (rmw if accepted)
// throughput: one item at a time; a frame walks the definition table one entry per
// cycle through the single read port of the definition ram until the first match or the last entry
// reset: async active low; afterwards a clearing pass writes every definition entry unused
// and every value entry empty, with no item taken meanwhile
module can_pdo_value_decoder_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    // input item
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index, def_object_id, def_type, can_id, data_length, frame_data, tick_ms
    input  logic [143:0] s_axis_tdata,
    // op, extended_frame, remote_frame
    input  logic [3:0]   s_axis_tuser,
    // result item
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // hit_index, raw_value, entry_valid, source_node, entry_receptions,
    // link_online, frames_accepted
    output logic [175:0] m_axis_tdata,
    // status
    output logic [2:0]   m_axis_tuser,
    // configuration: online_timeout_ms
    input  logic         cfg_wr_en,
    input  logic [19:0]  cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] LAST_CNT = CW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RMW   = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // input fields
    logic [1:0]  in_op;
    logic        in_ext;
    logic        in_rem;
    logic [6:0]  in_idx;
    logic [14:0] in_obj;
    logic [2:0]  in_type;
    logic [28:0] in_can_id;
    logic [3:0]  in_len;
    logic [63:0] in_data;
    logic [15:0] in_tick;
    logic        in_idx_ok;
    logic        s_accept;

    assign in_op     = s_axis_tuser[1:0];
    assign in_ext    = s_axis_tuser[2];
    assign in_rem    = s_axis_tuser[3];
    assign in_idx    = s_axis_tdata[cpvd_pkg::IDX_LSB +: 7];
    assign in_obj    = s_axis_tdata[cpvd_pkg::OBJ_LSB +: 15];
    assign in_type   = s_axis_tdata[cpvd_pkg::TYPE_LSB +: 3];
    assign in_can_id = s_axis_tdata[cpvd_pkg::CANID_LSB +: 29];
    assign in_len    = s_axis_tdata[cpvd_pkg::LEN_LSB +: 4];
    assign in_data   = s_axis_tdata[cpvd_pkg::DATA_LSB +: 64];
    assign in_tick   = s_axis_tdata[cpvd_pkg::TICK_LSB +: 16];
    assign in_idx_ok = 32'(in_idx) < 32'(TABLE_DEPTH);

    // registers
    logic [2:0]   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic         cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0] hit_idx_reg, hit_idx_next;
    logic [2:0]   hit_type_reg, hit_type_next;
    logic [14:0]  obj_reg, obj_next;
    logic [5:0]   node_reg, node_next;
    logic [3:0]   len_reg, len_next;
    logic [63:0]  data_reg, data_next;
    logic         rd_ok_reg, rd_ok_next;
    logic [2:0]   res_status_reg, res_status_next;
    logic [6:0]   res_hit_reg, res_hit_next;
    logic [63:0]  res_raw_reg, res_raw_next;
    logic         res_valid_reg, res_valid_next;
    logic [5:0]   res_node_reg, res_node_next;
    logic [31:0]  res_rec_reg, res_rec_next;
    logic [63:0]  total_reg, total_next;
    logic [31:0]  ms_reg, ms_next;
    logic [19:0]  timeout_reg, timeout_next;
    logic         m_valid_reg, m_valid_next;
    logic [2:0]   m_status_reg, m_status_next;
    logic [175:0] m_data_reg, m_data_next;

    // ram ports
    logic                  def_wr_en;
    logic [AW-1:0]         def_wr_addr;
    cpvd_pkg::def_entry_t  def_wr_data;
    logic [AW-1:0]         def_rd_addr;
    cpvd_pkg::def_entry_t  def_rd_data;
    logic                  val_wr_en;
    logic [AW-1:0]         val_wr_addr;
    cpvd_pkg::value_entry_t val_wr_data;
    logic [AW-1:0]         val_rd_addr;
    cpvd_pkg::value_entry_t val_rd_data;

    // helpers
    logic [3:0]  len_eff;
    logic        scan_match;
    logic [32:0] ms_sum;
    logic [31:0] rec_inc;
    logic [63:0] dec_value;
    logic        online;
    logic        out_free;

    cpvd_ram #(
        .WIDTH ($bits(cpvd_pkg::def_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_def_ram (
        .clk     (clk),
        .wr_en   (def_wr_en),
        .wr_addr (def_wr_addr),
        .wr_data (def_wr_data),
        .rd_addr (def_rd_addr),
        .rd_data (def_rd_data)
    );

    cpvd_ram #(
        .WIDTH ($bits(cpvd_pkg::value_entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

    // shared datapath pieces
    assign len_eff    = (len_reg > cpvd_pkg::MAX_BYTES) ? cpvd_pkg::MAX_BYTES : len_reg;
    assign scan_match = cmp_vld_reg && (def_rd_data.dtype != cpvd_pkg::TYPE_UNUSED)
                        && (def_rd_data.object_id == obj_reg);
    assign ms_sum     = {1'b0, ms_reg} + {17'd0, in_tick};
    assign rec_inc    = val_rd_data.receptions + 32'd1;
    assign dec_value  = cpvd_pkg::decode_value(hit_type_reg, data_reg);
    assign online     = (total_reg != 64'd0) && (ms_reg <= {12'd0, timeout_reg});
    assign out_free   = !m_valid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_type_next   = hit_type_reg;
        obj_next        = obj_reg;
        node_next       = node_reg;
        len_next        = len_reg;
        data_next       = data_reg;
        rd_ok_next      = rd_ok_reg;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        res_raw_next    = res_raw_reg;
        res_valid_next  = res_valid_reg;
        res_node_next   = res_node_reg;
        res_rec_next    = res_rec_reg;
        total_next      = total_reg;
        ms_next         = ms_reg;
        timeout_next    = cfg_wr_en ? cfg_wr_data : timeout_reg;
        m_valid_next    = (m_valid_reg && m_axis_tready) ? 1'b0 : m_valid_reg;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;

        def_wr_en   = 1'b0;
        def_wr_addr = AW'(in_idx);
        def_wr_data = '{object_id: in_obj, dtype: in_type};
        def_rd_addr = cnt_reg[AW-1:0];
        val_wr_en   = 1'b0;
        val_wr_addr = hit_idx_reg;
        val_wr_data = '{valid: 1'b1, node: node_reg, receptions: rec_inc, raw: dec_value};
        val_rd_addr = AW'(in_idx);

        unique case (state_reg)
            // clearing pass over both tables after reset
            S_CLEAR:
            begin
                def_wr_en   = 1'b1;
                def_wr_addr = cnt_reg[AW-1:0];
                def_wr_data = '{object_id: 15'd0, dtype: cpvd_pkg::TYPE_UNUSED};
                val_wr_en   = 1'b1;
                val_wr_addr = cnt_reg[AW-1:0];
                val_wr_data = '0;
                cnt_next    = cnt_reg + CW'(1);
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_IDLE;
                end
            end

            // take an item and start its operation
            S_IDLE:
            begin
                if (s_accept)
                begin
                    res_status_next = cpvd_pkg::STAT_IGNORED;
                    res_hit_next    = 7'd0;
                    res_raw_next    = 64'd0;
                    res_valid_next  = 1'b0;
                    res_node_next   = 6'd0;
                    res_rec_next    = 32'd0;
                    state_next      = S_DONE;
                    unique case (in_op)
                        cpvd_pkg::OP_LOAD:
                        begin
                            if (in_idx_ok)
                            begin
                                def_wr_en       = 1'b1;
                                res_status_next = cpvd_pkg::STAT_LOADED;
                            end
                        end
                        cpvd_pkg::OP_FRAME:
                        begin
                            if (in_ext && !in_rem)
                            begin
                                obj_next     = in_can_id[cpvd_pkg::ID_SHIFT +: 15];
                                node_next    = in_can_id[5:0];
                                len_next     = in_len;
                                data_next    = in_data;
                                cnt_next     = '0;
                                cmp_vld_next = 1'b0;
                                state_next   = S_SCAN;
                            end
                        end
                        cpvd_pkg::OP_TICK:
                        begin
                            ms_next         = ms_sum[32] ? 32'hFFFF_FFFF : ms_sum[31:0];
                            res_status_next = cpvd_pkg::STAT_TICKED;
                        end
                        cpvd_pkg::OP_READ:
                        begin
                            res_status_next = cpvd_pkg::STAT_READ;
                            res_hit_next    = in_idx;
                            rd_ok_next      = in_idx_ok;
                            state_next      = S_RDATA;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // first-match walk, one entry per cycle, compare in the cycle after the read
            S_SCAN:
            begin
                cmp_vld_next = (cnt_reg < DEPTH_CNT);
                cmp_idx_next = cnt_reg[AW-1:0];
                cnt_next     = cnt_reg + CW'(1);
                if (scan_match)
                begin
                    hit_idx_next  = cmp_idx_reg;
                    hit_type_next = def_rd_data.dtype;
                    if (len_eff < cpvd_pkg::type_bytes(def_rd_data.dtype))
                    begin
                        res_status_next = cpvd_pkg::STAT_SHORT;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        val_rd_addr = cmp_idx_reg;
                        state_next  = S_RMW;
                    end
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    res_status_next = cpvd_pkg::STAT_UNKNOWN;
                    state_next      = S_DONE;
                end
            end

            // update the matched value entry
            S_RMW:
            begin
                val_wr_en       = 1'b1;
                total_next      = total_reg + 64'd1;
                ms_next         = 32'd0;
                res_status_next = cpvd_pkg::STAT_ACCEPTED;
                res_hit_next    = 7'(hit_idx_reg);
                res_raw_next    = dec_value;
                res_valid_next  = 1'b1;
                res_node_next   = node_reg;
                res_rec_next    = rec_inc;
                state_next      = S_DONE;
            end

            // read entry data back
            S_RDATA:
            begin
                if (rd_ok_reg)
                begin
                    res_valid_next = val_rd_data.valid;
                    res_raw_next   = val_rd_data.valid ? val_rd_data.raw : 64'd0;
                    res_node_next  = val_rd_data.valid ? val_rd_data.node : 6'd0;
                    res_rec_next   = val_rd_data.receptions;
                end
                state_next = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = {1'b0, total_reg, online, res_rec_reg, res_node_reg,
                                     res_valid_reg, res_raw_reg, res_hit_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            total_reg   <= 64'd0;
            ms_reg      <= 32'd0;
            timeout_reg <= cpvd_pkg::TIMEOUT_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            total_reg   <= total_next;
            ms_reg      <= ms_next;
            timeout_reg <= timeout_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= cmp_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_type_reg   <= hit_type_next;
        obj_reg        <= obj_next;
        node_reg       <= node_next;
        len_reg        <= len_next;
        data_reg       <= data_next;
        rd_ok_reg      <= rd_ok_next;
        res_status_reg <= res_status_next;
        res_hit_reg    <= res_hit_next;
        res_raw_reg    <= res_raw_next;
        res_valid_reg  <= res_valid_next;
        res_node_reg   <= res_node_next;
        res_rec_reg    <= res_rec_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
    end

    // no item taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_axis_tready)
        else $error("item accepted during table clear");

    // accepted count grows by one at most per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> (total_reg == $past(total_reg) + 64'd1))
        else $error("frames accepted count jumped");

    // an acceptance restarts the age counter
    assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> (ms_reg == 32'd0))
        else $error("age not cleared on acceptance");

    // an accepted result shows a valid entry and an online link
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == cpvd_pkg::STAT_ACCEPTED))
            |-> (m_data_reg[71] && m_data_reg[110]))
        else $error("accepted result not valid or not online");

    // the walk never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (cnt_reg <= DEPTH_CNT))
        else $error("table walk ran past the last entry");

endmodule
